// ===== src/assert_macros.svh =====
// assertion macros used by the lexer core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== src/alx_pkg.sv =====
// types, character codes and helpers for the assembly line lexer
package alx_pkg;

  localparam int unsigned NameMaxDef = 15;
  localparam int unsigned NameBits   = 128;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeComment,
    ModeNumLead,
    ModeNumBody,
    ModeAddr,
    ModeIndr,
    ModeIndrClose,
    ModeCmd
  } lex_mode_e;

  typedef enum logic [1:0] {
    StatToken = 2'd0,
    StatEnd   = 2'd1,
    StatError = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    KindComma   = 3'd0,
    KindCommand = 3'd1,
    KindLabel   = 3'd2,
    KindReg     = 3'd3,
    KindImm     = 3'd4,
    KindAddr    = 3'd5,
    KindIndr    = 3'd6
  } kind_e;

  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChR      = 8'h52;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [31:0] number;
    logic [4:0]  name_length;
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic        last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
           (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic ends_name(input logic [7:0] c);
    return (c == ChComma) || (c == ChSpace) || (c == ChLf);
  endfunction

endpackage

// ===== src/assembly_line_lexer_core.sv =====
// assembly line lexer: byte stream in, tokens out through a small result queue
// results of an accepted byte are registered into the result queue and offered on the output behind any older results
// throughput: one byte per cycle while the input is not stalled; a byte yields zero, one or two results
// input stalls while the four-entry result queue holds three or more results
// an item with two results is offered one result at a time, the second marked by last_of_run_o
// reset (asynchronous, active low) empties the queue and returns to idle between tokens
`include "assert_macros.svh"

module assembly_line_lexer_core #(
  parameter int unsigned NameMax = alx_pkg::NameMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          byte_in_i,
  input  logic                end_of_input_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [2:0]          token_kind_o,
  output logic signed [31:0]  number_o,
  output logic [4:0]          name_length_o,
  output logic [63:0]         name_low_o,
  output logic [63:0]         name_high_o,
  output logic                last_of_run_o
);
  import alx_pkg::*;

  localparam int unsigned NameBytes = NameMax + 1;
  localparam logic [4:0]  CntBytes  = 5'(NameBytes);
  localparam logic [4:0]  CntMax    = 5'(NameMax);
  localparam int unsigned PtrW      = $clog2(QueueDepth);
  localparam int unsigned CntW      = $clog2(QueueDepth + 1);

  typedef logic [NameBytes-1:0][7:0] name_buf_t;

  // lexer state
  lex_mode_e   mode_q, mode_d;
  name_buf_t   name_q, name_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic        seen_q, seen_d;
  logic        failed_q, failed_d;
  logic        imm_q, imm_d;

  // result queue
  result_t             queue_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     qcnt_q;

  logic       in_acc, pop;
  logic [7:0] c;
  result_t    res_a, res_b, slot0, slot1, head;
  logic       va, vb;
  logic [1:0] push_cnt;

  name_buf_t  buf_app;
  logic [4:0] cnt_app;
  logic [34:0] prod;
  logic [31:0] limit;
  logic        ovf;

  function automatic result_t name_res(input kind_e k, input name_buf_t b,
                                       input logic [4:0] n);
    result_t r;
    logic [NameBits-1:0] w;
    r = '0;
    w = NameBits'(b);
    r.status      = StatToken;
    r.kind        = k;
    r.name_length = n;
    r.name_low    = w[63:0];
    r.name_high   = w[127:64];
    return r;
  endfunction

  // a trailing colon turns a command into a label and is dropped
  function automatic result_t cmd_res(input name_buf_t b, input logic [4:0] n);
    name_buf_t bb;
    logic      lab;
    bb  = b;
    lab = 1'b0;
    for (int i = 0; i < NameBytes; i++) begin
      if (n == 5'(i + 1) && b[i] == ChColon) begin
        lab   = 1'b1;
        bb[i] = '0;
      end
    end
    return name_res(lab ? KindLabel : KindCommand, bb, lab ? n - 5'd1 : n);
  endfunction

  function automatic result_t stat_res(input status_e s);
    result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  assign c      = byte_in_i;
  assign in_acc = in_valid_i && in_ready_o;

  // name with the current byte appended
  always_comb begin
    buf_app = name_q;
    cnt_app = cnt_q;
    for (int i = 0; i < NameBytes; i++) begin
      if (cnt_q == 5'(i)) buf_app[i] = c;
    end
    if (cnt_q < CntBytes) cnt_app = cnt_q + 5'd1;
  end

  // next decimal digit and overflow check against the signed range
  always_comb begin
    prod  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 35'(c[3:0]);
    limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    ovf   = prod > 35'(limit);
  end

  always_comb begin
    result_t num_r;
    logic    do_idle, clr, do_fail, bad;

    mode_d   = mode_q;
    name_d   = name_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    failed_d = failed_q;
    imm_d    = imm_q;
    res_a    = '0;
    res_b    = '0;
    va       = 1'b0;
    vb       = 1'b0;
    do_idle  = 1'b0;
    clr      = 1'b0;
    do_fail  = 1'b0;
    bad      = 1'b0;

    num_r        = '0;
    num_r.status = StatToken;
    num_r.kind   = imm_q ? KindImm : KindReg;
    num_r.number = neg_q ? (32'd0 - acc_q) : acc_q;

    if (end_of_input_i) begin
      if (!failed_q) begin
        unique case (mode_q)
          ModeNumBody: begin
            if (seen_q) begin
              va    = 1'b1;
              res_a = num_r;
            end else begin
              bad = 1'b1;
            end
          end
          ModeNumLead, ModeIndr, ModeIndrClose: bad = 1'b1;
          ModeAddr: begin
            if (cnt_q != 5'd0) begin
              va    = 1'b1;
              res_a = name_res(KindAddr, name_q, cnt_q);
            end else begin
              bad = 1'b1;
            end
          end
          ModeCmd: begin
            if (cnt_q >= 5'd2) begin
              va    = 1'b1;
              res_a = cmd_res(name_q, cnt_q);
            end else begin
              bad = 1'b1;
            end
          end
          default: ;
        endcase
        vb    = 1'b1;
        res_b = stat_res(bad ? StatError : StatEnd);
      end
      mode_d   = ModeIdle;
      clr      = 1'b1;
      failed_d = 1'b0;
      imm_d    = 1'b0;
    end else if (!failed_q) begin
      unique case (mode_q)
        ModeComment: begin
          if (c == ChLf) mode_d = ModeIdle;
        end
        ModeNumLead: begin
          if (is_space(c)) begin
          end else if (c == ChPlus || c == ChMinus) begin
            neg_d  = (c == ChMinus);
            mode_d = ModeNumBody;
          end else if (is_digit(c)) begin
            if (ovf) begin
              do_fail = 1'b1;
            end else begin
              acc_d  = prod[31:0];
              seen_d = 1'b1;
              mode_d = ModeNumBody;
            end
          end else begin
            do_fail = 1'b1;
          end
        end
        ModeNumBody: begin
          if (is_digit(c)) begin
            if (ovf) begin
              do_fail = 1'b1;
            end else begin
              acc_d  = prod[31:0];
              seen_d = 1'b1;
            end
          end else if (seen_q) begin
            va      = 1'b1;
            res_a   = num_r;
            do_idle = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        ModeAddr: begin
          if (ends_name(c)) begin
            if (cnt_q == 5'd0) begin
              do_fail = 1'b1;
            end else begin
              va      = 1'b1;
              res_a   = name_res(KindAddr, name_q, cnt_q);
              do_idle = 1'b1;
            end
          end else begin
            name_d = buf_app;
            cnt_d  = cnt_app;
            if (cnt_app >= CntMax) begin
              va     = 1'b1;
              res_a  = name_res(KindAddr, buf_app, cnt_app);
              mode_d = ModeIdle;
              clr    = 1'b1;
            end
          end
        end
        ModeIndr: begin
          if (c == ChRParen) begin
            if (cnt_q == 5'd0) begin
              do_fail = 1'b1;
            end else begin
              va     = 1'b1;
              res_a  = name_res(KindIndr, name_q, cnt_q);
              mode_d = ModeIdle;
              clr    = 1'b1;
            end
          end else begin
            name_d = buf_app;
            cnt_d  = cnt_app;
            if (cnt_app >= CntMax) mode_d = ModeIndrClose;
          end
        end
        ModeIndrClose: begin
          if (c == ChRParen) begin
            va     = 1'b1;
            res_a  = name_res(KindIndr, name_q, cnt_q);
            mode_d = ModeIdle;
            clr    = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        ModeCmd: begin
          if (ends_name(c)) begin
            if (cnt_q < 5'd2) begin
              do_fail = 1'b1;
            end else begin
              va      = 1'b1;
              res_a   = cmd_res(name_q, cnt_q);
              do_idle = 1'b1;
            end
          end else begin
            name_d = buf_app;
            cnt_d  = cnt_app;
            if (cnt_app >= CntBytes) begin
              va     = 1'b1;
              res_a  = cmd_res(buf_app, cnt_app);
              mode_d = ModeIdle;
              clr    = 1'b1;
            end
          end
        end
        default: do_idle = 1'b1;
      endcase
    end

    if (do_fail) begin
      va       = 1'b1;
      res_a    = stat_res(StatError);
      failed_d = 1'b1;
      mode_d   = ModeIdle;
      clr      = 1'b1;
    end

    if (clr || do_idle) begin
      name_d = '0;
      cnt_d  = 5'd0;
      acc_d  = 32'd0;
      neg_d  = 1'b0;
      seen_d = 1'b0;
    end

    // a byte read while idle, or the byte that ended a token without being part of it, starts whatever follows
    if (do_idle) begin
      mode_d = ModeIdle;
      priority if (is_space(c)) begin
      end else if (c == ChSemi) begin
        mode_d = ModeComment;
      end else if (c == ChComma) begin
        vb         = 1'b1;
        res_b      = stat_res(StatToken);
        res_b.kind = KindComma;
      end else if (c == ChR || c == ChHash) begin
        imm_d  = (c == ChHash);
        mode_d = ModeNumLead;
      end else if (c == ChAt) begin
        mode_d = ModeAddr;
      end else if (c == ChLParen) begin
        mode_d = ModeIndr;
      end else begin
        name_d[0] = c;
        cnt_d     = 5'd1;
        mode_d    = ModeCmd;
      end
    end
  end

  // pack results into queue slots and mark the last one of the item
  always_comb begin
    slot0    = va ? res_a : res_b;
    slot1    = res_b;
    push_cnt = 2'(va) + 2'(vb);
    if (!in_acc) push_cnt = 2'd0;
    if (va && vb) slot1.last = 1'b1;
    else          slot0.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      name_q   <= '0;
      cnt_q    <= 5'd0;
      acc_q    <= 32'd0;
      neg_q    <= 1'b0;
      seen_q   <= 1'b0;
      failed_q <= 1'b0;
      imm_q    <= 1'b0;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      name_q   <= name_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      seen_q   <= seen_d;
      failed_q <= failed_d;
      imm_q    <= imm_d;
    end
  end

  assign head        = queue_q[rd_ptr_q];
  assign out_valid_o = (qcnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (qcnt_q <= CntW'(QueueDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) queue_q[wr_ptr_q] <= slot0;
    if (push_cnt == 2'd2) queue_q[wr_ptr_q + PtrW'(1)] <= slot1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      qcnt_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      qcnt_q <= qcnt_q + CntW'(push_cnt) - CntW'(pop);
    end
  end

  assign status_o      = head.status;
  assign token_kind_o  = head.kind;
  assign number_o      = signed'(head.number);
  assign name_length_o = head.name_length;
  assign name_low_o    = head.name_low;
  assign name_high_o   = head.name_high;
  assign last_of_run_o = head.last;

  `ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, qcnt_q > CntW'(QueueDepth), "result queue overflow")
  `ASSERT_CLK(a_push_needs_accept, clk_i, rst_ni, (push_cnt != 2'd0) |-> in_acc, "results pushed without a transaction")
  `ASSERT_CLK(a_failed_silent, clk_i, rst_ni, (in_acc && failed_q && !end_of_input_i) |-> (push_cnt == 2'd0), "result produced after a syntax error")
  `ASSERT_CLK(a_end_resets, clk_i, rst_ni, (in_acc && end_of_input_i) |=> (mode_q == ModeIdle && !failed_q && cnt_q == 5'd0), "end marker did not restore idle state")
  `ASSERT_NEVER(a_name_bound, clk_i, rst_ni, cnt_q > CntBytes, "name count beyond buffer")

endmodule
